// ===== sv/cdt_pkg.sv =====
package cdt_pkg;

    localparam int FIELD_W    = 7;
    localparam int NUM_FIELDS = 7;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] IDX_SEC   = 3'd0;
    localparam logic [IDX_W-1:0] IDX_MIN   = 3'd1;
    localparam logic [IDX_W-1:0] IDX_HOUR  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_WDAY  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_DAY   = 3'd4;
    localparam logic [IDX_W-1:0] IDX_MONTH = 3'd5;
    localparam logic [IDX_W-1:0] IDX_YEAR  = 3'd6;

    localparam logic [FIELD_W-1:0] YEAR_HI   = 7'd99;
    localparam logic [FIELD_W-1:0] MONTH_HI  = 7'd12;
    localparam logic [FIELD_W-1:0] HOUR_HI   = 7'd23;
    localparam logic [FIELD_W-1:0] MINUTE_HI = 7'd59;
    localparam logic [FIELD_W-1:0] WDAY_HI   = 7'd7;
    localparam logic [FIELD_W-1:0] FEB_LEAP  = 7'd29;
    localparam logic [FIELD_W-1:0] FEB_DAYS  = 7'd28;
    localparam logic [FIELD_W-1:0] SHORT_MON = 7'd30;
    localparam logic [FIELD_W-1:0] LONG_MON  = 7'd31;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_INC  = 2'd1,
        OP_DEC  = 2'd2,
        OP_SET  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_YEAR   = 3'd1,
        STEP_MONTH  = 3'd2,
        STEP_DAY    = 3'd3,
        STEP_HOUR   = 3'd4,
        STEP_MINUTE = 3'd5,
        STEP_WDAY   = 3'd6
    } t_step;

    typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] t_fields;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [FIELD_W-1:0] data;
    } t_fwr;

    typedef struct packed {
        logic [FIELD_W-1:0] year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] wday;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic               wreq;
        logic [2:0]         step;
    } t_res;

endpackage

// ===== sv/cdt_field_store.sv =====
module cdt_field_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cdt_pkg::t_fwr   i_wr,
    output cdt_pkg::t_fields o_fields,
    output cdt_pkg::t_fields o_fields_next
);

    cdt_pkg::t_fields r_fld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fld <= '0;
        end else if (i_wr.we) begin
            r_fld[i_wr.addr] <= i_wr.data;
        end
    end

    // write-through view: state as it stands after this beat
    always_comb begin
        o_fields_next = r_fld;
        if (i_wr.we) begin
            o_fields_next[i_wr.addr] = i_wr.data;
        end
    end

    assign o_fields = r_fld;

endmodule

// ===== sv/cdt_edit_unit.sv =====
module cdt_edit_unit (
    input  cdt_pkg::t_step   i_step,
    input  logic             i_go,
    input  cdt_pkg::t_op     i_op,
    input  logic [cdt_pkg::IDX_W-1:0]   i_idx,
    input  logic [cdt_pkg::FIELD_W-1:0] i_value,
    input  cdt_pkg::t_fields i_fields,
    output cdt_pkg::t_step   o_step_next,
    output logic             o_wreq,
    output cdt_pkg::t_fwr    o_wr
);

    logic [cdt_pkg::IDX_W-1:0]   tgt;
    logic [cdt_pkg::FIELD_W-1:0] lo;
    logic [cdt_pkg::FIELD_W-1:0] hi;
    logic [cdt_pkg::FIELD_W-1:0] mdays;
    logic [cdt_pkg::FIELD_W-1:0] v;
    logic [cdt_pkg::FIELD_W:0]   v_inc;
    logic [cdt_pkg::FIELD_W-1:0] month;

    assign month = i_fields[cdt_pkg::IDX_MONTH];

    always_comb begin
        case (month)
            7'd2: begin
                mdays = (i_fields[cdt_pkg::IDX_YEAR][1:0] == 2'b00) ?
                        cdt_pkg::FEB_LEAP : cdt_pkg::FEB_DAYS;
            end
            7'd4, 7'd6, 7'd9, 7'd11: mdays = cdt_pkg::SHORT_MON;
            default:                 mdays = cdt_pkg::LONG_MON;
        endcase
    end

    always_comb begin
        case (i_step)
            cdt_pkg::STEP_YEAR: begin
                tgt = cdt_pkg::IDX_YEAR;  lo = 7'd0; hi = cdt_pkg::YEAR_HI;
            end
            cdt_pkg::STEP_MONTH: begin
                tgt = cdt_pkg::IDX_MONTH; lo = 7'd1; hi = cdt_pkg::MONTH_HI;
            end
            cdt_pkg::STEP_DAY: begin
                tgt = cdt_pkg::IDX_DAY;   lo = 7'd1; hi = mdays;
            end
            cdt_pkg::STEP_HOUR: begin
                tgt = cdt_pkg::IDX_HOUR;  lo = 7'd0; hi = cdt_pkg::HOUR_HI;
            end
            cdt_pkg::STEP_MINUTE: begin
                tgt = cdt_pkg::IDX_MIN;   lo = 7'd0; hi = cdt_pkg::MINUTE_HI;
            end
            default: begin
                tgt = cdt_pkg::IDX_WDAY;  lo = 7'd1; hi = cdt_pkg::WDAY_HI;
            end
        endcase
    end

    assign v     = i_fields[tgt];
    assign v_inc = {1'b0, v} + 8'd1;

    // next step
    always_comb begin
        o_step_next = i_step;
        if (i_go && i_op == cdt_pkg::OP_SET) begin
            case (i_step)
                cdt_pkg::STEP_IDLE:   o_step_next = cdt_pkg::STEP_YEAR;
                cdt_pkg::STEP_YEAR:   o_step_next = cdt_pkg::STEP_MONTH;
                cdt_pkg::STEP_MONTH:  o_step_next = cdt_pkg::STEP_DAY;
                cdt_pkg::STEP_DAY:    o_step_next = cdt_pkg::STEP_HOUR;
                cdt_pkg::STEP_HOUR:   o_step_next = cdt_pkg::STEP_MINUTE;
                cdt_pkg::STEP_MINUTE: o_step_next = cdt_pkg::STEP_WDAY;
                default:              o_step_next = cdt_pkg::STEP_IDLE;
            endcase
        end
    end

    // field write and request flag
    always_comb begin
        o_wr   = '0;
        o_wreq = 1'b0;
        if (i_go) begin
            if (i_step == cdt_pkg::STEP_IDLE) begin
                case (i_op)
                    cdt_pkg::OP_LOAD: begin
                        o_wr.we   = (i_idx != 3'd7);
                        o_wr.addr = i_idx;
                        o_wr.data = i_value;
                    end
                    cdt_pkg::OP_SET: begin
                        o_wr.we   = 1'b1;
                        o_wr.addr = cdt_pkg::IDX_SEC;
                        o_wr.data = '0;
                    end
                    default: o_wr = '0;
                endcase
            end else begin
                o_wr.addr = tgt;
                case (i_op)
                    cdt_pkg::OP_INC: begin
                        o_wr.we   = 1'b1;
                        o_wr.data = (v_inc > {1'b0, hi}) ? lo : v_inc[cdt_pkg::FIELD_W-1:0];
                    end
                    cdt_pkg::OP_DEC: begin
                        o_wr.we   = 1'b1;
                        o_wr.data = (v == '0 || v <= lo) ? hi : v - 7'd1;
                    end
                    cdt_pkg::OP_SET: begin
                        o_wr.we   = (v > hi);
                        o_wr.data = hi;
                        o_wreq    = (i_step == cdt_pkg::STEP_WDAY);
                    end
                    default: o_wr.we = 1'b0;
                endcase
            end
        end
    end

endmodule

// ===== sv/clock_date_time_field_editor.sv =====
// Channel  Dir  Bus              Contents
// s        in   tdata[15:0]      field_index, value (lowest bits first), zero fill
//               tuser[1:0]       op
// m        out  tdata[55:0]      edit_step, write_request, second, minute, hour,
//                                weekday, day, month, year, zero fill
//
// One beat in, one beat out; the result is registered in the output register or the skid entry before it appears on m.
// s takes a beat every cycle while m keeps up; the field update is a read-modify-write
// on the field store within the accepting cycle.
// Output register plus one skid entry: with the register full and m stalled, one more
// beat goes to the skid, then s_tready stays low until m takes a beat.
// Synchronous active-low reset clears all fields and returns to idle.
module clock_date_time_field_editor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [cdt_pkg::IN_DATA_W-1:0]   i_s_tdata,  // field_index, value
    input  logic [cdt_pkg::IN_USER_W-1:0]   i_s_tuser,  // op
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cdt_pkg::OUT_DATA_W-1:0]  o_m_tdata   // step, wreq, sec..year
);

    cdt_pkg::t_step   r_step;
    cdt_pkg::t_step   n_step;
    cdt_pkg::t_fields fields;
    cdt_pkg::t_fields fields_next;
    cdt_pkg::t_fwr    wr;
    cdt_pkg::t_res    res;
    cdt_pkg::t_res    r_out;
    cdt_pkg::t_res    r_skid;
    logic             r_out_v;
    logic             r_skid_v;
    logic             wreq;
    logic             push;
    logic             pop;

    assign o_s_tready = !r_skid_v;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = r_out_v && i_m_tready;

    cdt_edit_unit u_edit (
        .i_step      (r_step),
        .i_go        (push),
        .i_op        (cdt_pkg::t_op'(i_s_tuser)),
        .i_idx       (i_s_tdata[2:0]),
        .i_value     (i_s_tdata[9:3]),
        .i_fields    (fields),
        .o_step_next (n_step),
        .o_wreq      (wreq),
        .o_wr        (wr)
    );

    cdt_field_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (wr),
        .o_fields      (fields),
        .o_fields_next (fields_next)
    );

    always_comb begin
        res.step   = n_step;
        res.wreq   = wreq;
        res.second = fields_next[cdt_pkg::IDX_SEC];
        res.minute = fields_next[cdt_pkg::IDX_MIN];
        res.hour   = fields_next[cdt_pkg::IDX_HOUR];
        res.wday   = fields_next[cdt_pkg::IDX_WDAY];
        res.day    = fields_next[cdt_pkg::IDX_DAY];
        res.month  = fields_next[cdt_pkg::IDX_MONTH];
        res.year   = fields_next[cdt_pkg::IDX_YEAR];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= cdt_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else if (push) begin
                r_out <= res;
            end else begin
                r_out_v <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_v) begin
                r_out   <= res;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= res;
                r_skid_v <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {3'b000, r_out};

endmodule
